// ===== hw/rtl/reciprocal_frequency_counter_top_macros.svh =====
// Assertion macros used by the checker file of the frequency counter.
`ifndef RECIPROCAL_FREQUENCY_COUNTER_TOP_MACROS_SVH
`define RECIPROCAL_FREQUENCY_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define RFC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define RFC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rfc_pkg.sv =====
// Package of the reciprocal frequency counter: widths, codes and transfer types.
package rfc_pkg;

   // Count and fixed-point sizing
   localparam int COUNT_WIDTH   = 32;
   localparam int FRACTION_BITS = 8;

   // Fixed field widths
   localparam int STAMP_W     = 32;
   localparam int DIV_W       = 16;
   localparam int CLK_W       = 32;
   localparam int FREQ_W      = 40;
   localparam int MODE_W      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Engine sizing, all derived
   localparam int DIGIT_W = DIV_W;
   localparam int K_W     = DIV_W + CLK_W;
   localparam int NDIG    = (COUNT_WIDTH + DIGIT_W - 1) / DIGIT_W;
   localparam int PAD_W   = NDIG * DIGIT_W;
   localparam int MUL_W   = DIGIT_W + K_W;
   localparam int PROD_W  = COUNT_WIDTH + K_W;
   localparam int NUM_W   = PROD_W + FRACTION_BITS;
   localparam int HI_W    = NUM_W - FREQ_W;
   localparam int STEP_W  = $clog2(FREQ_W);

   // Command codes
   localparam logic [MODE_W-1:0] MODE_ARM        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_EDGE       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REQ_SNAP   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ_SNAP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ_FINAL = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DIVIDER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLOCK   = 2'd1;

   // Register reset values
   localparam logic [DIV_W-1:0] DIVIDER_RESET = 16'd1;
   localparam logic [CLK_W-1:0] CLOCK_RESET   = 32'd72000000;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [STAMP_W-1:0] timestamp;
   } req_type;

   typedef struct packed {
      logic              valid_res;
      logic [FREQ_W-1:0] frequency;
   } rsp_type;

   // Control to engine
   typedef struct packed {
      logic      start;
      count_type pulses;
      count_type cycles;
   } eng_cmd_type;

   // Engine to control
   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] freq;
   } eng_stat_type;

endpackage

// ===== hw/rtl/rfc_engine.sv =====
// Frequency engine: shared 16x48 multiplier builds the numerator, then restoring division.
module rfc_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  rfc_pkg::eng_cmd_type       cmd,
   input  logic [rfc_pkg::DIV_W-1:0]  divider_ratio,
   input  logic [rfc_pkg::CLK_W-1:0]  clock_rate_hz,
   output rfc_pkg::eng_stat_type      stat
);
   import rfc_pkg::*;

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_SCALE = 3'd1;
   localparam logic [2:0] E_MUL   = 3'd2;
   localparam logic [2:0] E_CHECK = 3'd3;
   localparam logic [2:0] E_DIV   = 3'd4;
   localparam logic [2:0] E_DONE  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic [PAD_W-1:0]       dig_ff, dig_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] den_ff, den_in;
   logic [FREQ_W-1:0]      lo_ff, lo_in;

   logic [DIGIT_W-1:0]     mul_a;
   logic [K_W-1:0]         mul_b;
   logic [MUL_W-1:0]       mul_p;
   logic [NUM_W-1:0]       num;
   logic [COUNT_WIDTH:0]   shifted;
   logic                   fits;

   // Shared multiplier: divider times clock first, then one pulse digit a cycle
   always_comb begin
      if (state_ff == E_SCALE) begin
         mul_a = divider_ratio;
         mul_b = K_W'(clock_rate_hz);
      end else begin
         mul_a = dig_ff[PAD_W-1 -: DIGIT_W];
         mul_b = k_ff;
      end
   end
   assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

   // Numerator with fraction bits appended
   assign num = NUM_W'(acc_ff) << FRACTION_BITS;

   // Division step: bring in the next dividend bit and try the subtract
   assign shifted = {rem_ff, lo_ff[FREQ_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      dig_in   = dig_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      lo_in    = lo_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               dig_in   = PAD_W'(cmd.pulses);
               den_in   = cmd.cycles;
               acc_in   = '0;
               state_in = E_SCALE;
            end
         end
         E_SCALE: begin
            k_in     = mul_p[K_W-1:0];
            step_in  = STEP_W'(NDIG - 1);
            state_in = E_MUL;
         end
         E_MUL: begin
            acc_in = (acc_ff << DIGIT_W) + PROD_W'(mul_p);
            dig_in = dig_ff << DIGIT_W;
            if (step_ff == '0) begin
               state_in = E_CHECK;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         E_CHECK: begin
            // quotient fits in the result width only if the top part is below the divisor
            if (num[NUM_W-1:FREQ_W] >= HI_W'(den_ff)) begin
               lo_in    = '1;
               state_in = E_DONE;
            end else begin
               rem_in   = num[FREQ_W +: COUNT_WIDTH];
               lo_in    = num[FREQ_W-1:0];
               step_in  = STEP_W'(FREQ_W - 1);
               state_in = E_DIV;
            end
         end
         E_DIV: begin
            if (fits) begin
               rem_in = COUNT_WIDTH'(shifted - {1'b0, den_ff});
            end else begin
               rem_in = shifted[COUNT_WIDTH-1:0];
            end
            lo_in = {lo_ff[FREQ_W-2:0], fits};
            if (step_ff == '0) begin
               state_in = E_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         E_DONE: begin
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      k_ff    <= k_in;
      dig_ff  <= dig_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      lo_ff   <= lo_in;
   end

   assign stat.done = state_ff == E_DONE;
   assign stat.freq = lo_ff;

endmodule

// ===== hw/rtl/reciprocal_frequency_counter_top.sv =====
// Top level of the reciprocal frequency counter: command handling, counts and result register.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_data  (mode, timestamp)
//   rsp      out        rsp_valid / rsp_ready   rsp_data  (valid_res, frequency)
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// Arm, edge, request, unused modes and reads that answer valid 0 are answered in the
// cycle after they are taken. A computing read runs the engine through a scale step,
// NDIG multiply steps, one range check and FREQ_W division steps; a saturating one
// skips the division. The engine has a 16x48 multiplier and a one-bit-a-cycle divider.
// Reset is synchronous and clears all counts and modes; csr_ready is always high.
// A pending result holds rsp_data and blocks new commands until rsp_ready.
module reciprocal_frequency_counter_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rfc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rfc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rfc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rfc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rfc_pkg::*;

   localparam logic ST_READY = 1'b0;
   localparam logic ST_CALC  = 1'b1;

   localparam logic [1:0] RUN_IDLE   = 2'd0;
   localparam logic [1:0] RUN_ARMED  = 2'd1;
   localparam logic [1:0] RUN_PULSES = 2'd2;

   localparam logic [1:0] SNAP_IDLE    = 2'd0;
   localparam logic [1:0] SNAP_WAITING = 2'd1;
   localparam logic [1:0] SNAP_READY   = 2'd2;

   logic               ctl_ff, ctl_in;
   logic [1:0]         run_ff, run_in;
   logic [1:0]         snap_ff, snap_in;
   logic [STAMP_W-1:0] last_stamp_ff, last_stamp_in;
   count_type          cycle_total_ff, cycle_total_in;
   count_type          pulse_count_ff, pulse_count_in;
   count_type          snap_cycles_ff, snap_cycles_in;
   count_type          snap_pulses_ff, snap_pulses_in;
   logic [DIV_W-1:0]   divider_ff;
   logic [CLK_W-1:0]   clock_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               rsp_load;
   eng_cmd_type        eng_cmd;
   eng_stat_type       eng_stat;
   logic [STAMP_W-1:0] elapsed;
   count_type          pulse_next;
   count_type          cycle_next;

   assign req_ready = (ctl_ff == ST_READY) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Edge arithmetic
   assign elapsed    = req_data.timestamp - last_stamp_ff;
   assign pulse_next = pulse_count_ff + 1'b1;
   assign cycle_next = cycle_total_ff + COUNT_WIDTH'(elapsed);

   // Command handling and sequencing
   always_comb begin
      ctl_in         = ctl_ff;
      run_in         = run_ff;
      snap_in        = snap_ff;
      last_stamp_in  = last_stamp_ff;
      cycle_total_in = cycle_total_ff;
      pulse_count_in = pulse_count_ff;
      snap_cycles_in = snap_cycles_ff;
      snap_pulses_in = snap_pulses_ff;
      rsp_load       = 1'b0;
      rsp_data_in    = '0;
      eng_cmd        = '0;
      unique case (ctl_ff)
         ST_READY: begin
            if (accept) begin
               rsp_load = 1'b1;
               unique case (req_data.mode)
                  MODE_ARM: begin
                     snap_in        = SNAP_IDLE;
                     cycle_total_in = '0;
                     last_stamp_in  = '0;
                     pulse_count_in = '0;
                     snap_cycles_in = '0;
                     snap_pulses_in = '0;
                     run_in         = RUN_ARMED;
                  end
                  MODE_EDGE: begin
                     if (run_ff == RUN_PULSES) begin
                        pulse_count_in = pulse_next;
                        cycle_total_in = cycle_next;
                        last_stamp_in  = req_data.timestamp;
                        if (snap_ff == SNAP_WAITING) begin
                           snap_pulses_in = pulse_next;
                           snap_cycles_in = cycle_next;
                           snap_in        = SNAP_READY;
                        end
                     end else if (run_ff == RUN_ARMED) begin
                        last_stamp_in  = req_data.timestamp;
                        cycle_total_in = '0;
                        pulse_count_in = '0;
                        run_in         = RUN_PULSES;
                     end
                  end
                  MODE_REQ_SNAP: begin
                     snap_cycles_in = '0;
                     snap_pulses_in = '0;
                     snap_in        = SNAP_WAITING;
                  end
                  MODE_READ_SNAP: begin
                     if (snap_ff == SNAP_READY && snap_cycles_ff != '0) begin
                        rsp_load       = 1'b0;
                        eng_cmd.start  = 1'b1;
                        eng_cmd.pulses = snap_pulses_ff;
                        eng_cmd.cycles = snap_cycles_ff;
                        ctl_in         = ST_CALC;
                     end
                  end
                  MODE_READ_FINAL: begin
                     if (run_ff == RUN_PULSES) begin
                        run_in = RUN_IDLE;
                        if (cycle_total_ff != '0) begin
                           rsp_load       = 1'b0;
                           eng_cmd.start  = 1'b1;
                           eng_cmd.pulses = pulse_count_ff;
                           eng_cmd.cycles = cycle_total_ff;
                           ctl_in         = ST_CALC;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CALC: begin
            // hand the finished quotient to the result register
            if (eng_stat.done) begin
               rsp_load              = 1'b1;
               rsp_data_in.valid_res = 1'b1;
               rsp_data_in.frequency = eng_stat.freq;
               ctl_in                = ST_READY;
            end
         end
         default: begin
            ctl_in = ST_READY;
         end
      endcase
   end

   // Result register: load on a new result, drop on transfer
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff         <= ST_READY;
         run_ff         <= RUN_IDLE;
         snap_ff        <= SNAP_IDLE;
         last_stamp_ff  <= '0;
         cycle_total_ff <= '0;
         pulse_count_ff <= '0;
         snap_cycles_ff <= '0;
         snap_pulses_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ctl_ff         <= ctl_in;
         run_ff         <= run_in;
         snap_ff        <= snap_in;
         last_stamp_ff  <= last_stamp_in;
         cycle_total_ff <= cycle_total_in;
         pulse_count_ff <= pulse_count_in;
         snap_cycles_ff <= snap_cycles_in;
         snap_pulses_ff <= snap_pulses_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold result payload until replaced
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= DIVIDER_RESET;
         clock_ff   <= CLOCK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DIVIDER: divider_ff <= csr_data[DIV_W-1:0];
            REG_CLOCK:   clock_ff   <= csr_data[CLK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rfc_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cmd           (eng_cmd),
      .divider_ratio (divider_ff),
      .clock_rate_hz (clock_ff),
      .stat          (eng_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/rfc_checker.sv =====
// Port-level checks of the frequency counter and their bind to the top level.
`include "reciprocal_frequency_counter_top_macros.svh"

module rfc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rfc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rfc_pkg::rsp_type rsp_data
);
   import rfc_pkg::*;

   // A stalled result keeps its value
   `RFC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // No new command while a result is stuck
   `RFC_ASSERT_NOW(a_no_accept_on_stall, rsp_valid && !rsp_ready, !req_ready, "command taken while result stalled")

   // Commands other than reads answer at once with no measurement
   `RFC_ASSERT_NEXT(a_cmd_answer, req_valid && req_ready && req_data.mode != MODE_READ_SNAP && req_data.mode != MODE_READ_FINAL, rsp_valid && !rsp_data.valid_res, "non-read command did not answer")

   // An empty answer carries a zero frequency
   `RFC_ASSERT_NOW(a_empty_zero, rsp_valid && !rsp_data.valid_res, rsp_data.frequency == '0, "empty answer with nonzero frequency")

endmodule

bind reciprocal_frequency_counter_top rfc_checker u_rfc_checker (.*);

// ===== sim/reciprocal_frequency_counter_top_tb.sv =====
// Self-checking testbench for the reciprocal frequency counter: predicted results vs. DUT.
module reciprocal_frequency_counter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rfc_pkg::*;

   // Modes the block ignores and register indexes it does not decode
   localparam logic [MODE_W-1:0]      MODE_UNUSED_5 = 3'd5;
   localparam logic [MODE_W-1:0]      MODE_UNUSED_6 = 3'd6;
   localparam logic [MODE_W-1:0]      MODE_UNUSED_7 = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3   = 2'd3;

   localparam logic [FREQ_W-1:0] FREQ_LIMIT    = '1;
   localparam int                RANDOM_ITEMS  = 1600;
   localparam int                MAX_WAIT      = 18;
   localparam int                SETTLE_CYCLES = 64;

   typedef enum logic [1:0] {CNT_IDLE, CNT_ARMED, CNT_COUNTING} counter_phase_type;
   typedef enum logic [1:0] {SNAP_NONE, SNAP_WAIT, SNAP_HELD} snap_phase_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Predicted block state, starting from its reset values
   logic [DIV_W-1:0]   divider_setting = DIVIDER_RESET;
   logic [CLK_W-1:0]   clock_setting   = CLOCK_RESET;
   counter_phase_type  counter_phase   = CNT_IDLE;
   snap_phase_type     snap_phase      = SNAP_NONE;
   logic [STAMP_W-1:0] last_stamp      = '0;
   count_type          cycle_total     = '0;
   count_type          pulse_count     = '0;
   count_type          snap_cycles     = '0;
   count_type          snap_pulses     = '0;

   rsp_type pending_results[$];
   int      error_count = 0;
   int      items_sent  = 0;
   bit      send_burst  = 1'b0;
   bit      recv_burst  = 1'b0;
   bit      req_held    = 1'b0;

   reciprocal_frequency_counter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #2_000_000;
      $display("reciprocal_frequency_counter_top: mismatch");
      $finish;
   end

   // pulses * divider * clock * 2^FRACTION_BITS / cycles, truncated and saturated
   function automatic logic [FREQ_W-1:0] scaled_frequency(count_type pulses, count_type cycles);
      logic [127:0] numerator;
      logic [127:0] quotient;
      numerator = 128'(pulses) * 128'(divider_setting) * 128'(clock_setting);
      numerator = numerator << FRACTION_BITS;
      quotient  = numerator / 128'(cycles);
      if (quotient > 128'(FREQ_LIMIT))
         return FREQ_LIMIT;
      return quotient[FREQ_W-1:0];
   endfunction

   // Advance the predicted state by one command and return its answer
   function automatic rsp_type predict_response(req_type item);
      rsp_type            answer;
      logic [STAMP_W-1:0] elapsed;
      answer = '0;
      case (item.mode)
         MODE_ARM: begin
            snap_phase    = SNAP_NONE;
            cycle_total   = '0;
            last_stamp    = '0;
            pulse_count   = '0;
            snap_cycles   = '0;
            snap_pulses   = '0;
            counter_phase = CNT_ARMED;
         end
         MODE_EDGE: begin
            if (counter_phase == CNT_COUNTING) begin
               elapsed     = item.timestamp - last_stamp;
               pulse_count = pulse_count + 1'b1;
               cycle_total = cycle_total + count_type'(elapsed);
               last_stamp  = item.timestamp;
               if (snap_phase == SNAP_WAIT) begin
                  snap_pulses = pulse_count;
                  snap_cycles = cycle_total;
                  snap_phase  = SNAP_HELD;
               end
            end else if (counter_phase == CNT_ARMED) begin
               last_stamp    = item.timestamp;
               cycle_total   = '0;
               pulse_count   = '0;
               counter_phase = CNT_COUNTING;
            end
         end
         MODE_REQ_SNAP: begin
            snap_cycles = '0;
            snap_pulses = '0;
            snap_phase  = SNAP_WAIT;
         end
         MODE_READ_SNAP: begin
            if (snap_phase == SNAP_HELD && snap_cycles != '0) begin
               answer.valid_res = 1'b1;
               answer.frequency = scaled_frequency(snap_pulses, snap_cycles);
            end
         end
         MODE_READ_FINAL: begin
            if (counter_phase == CNT_COUNTING) begin
               counter_phase = CNT_IDLE;
               if (cycle_total != '0) begin
                  answer.valid_res = 1'b1;
                  answer.frequency = scaled_frequency(pulse_count, cycle_total);
               end
            end
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   // Transfer one command; valid stays high when the next one follows at once
   task automatic send_item(logic [MODE_W-1:0] cmd, logic [STAMP_W-1:0] stamp);
      int      gap;
      req_type item;
      gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         if (req_held) begin
            req_valid <= 1'b0;
            req_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      item.mode      = cmd;
      item.timestamp = stamp;
      req_valid <= 1'b1;
      req_data  <= item;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_response(item));
      items_sent++;
   endtask

   // Drop the request and hold until every predicted result has arrived
   task automatic drain_results();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Transfer one register write while the block is idle
   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_DIVIDER: divider_setting = value[DIV_W-1:0];
         REG_CLOCK:   clock_setting   = value;
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Reads and edges before any arm, plus the ignored modes
   task automatic test_idle_commands();
      send_item(MODE_READ_SNAP, 32'h0000_0000);
      send_item(MODE_READ_FINAL, 32'hFFFF_FFFF);
      send_item(MODE_EDGE, 32'h1234_5678);
      send_item(MODE_UNUSED_5, 32'hFFFF_FFFF);
      send_item(MODE_UNUSED_7, 32'h0000_0000);
   endtask

   // Measurement whose timestamps wrap, with an early and a ready snapshot read
   task automatic test_wrapping_measurement();
      send_item(MODE_ARM, 32'hA5A5_5A5A);
      send_item(MODE_EDGE, 32'hFFFF_FFF0);
      send_item(MODE_EDGE, 32'h0000_0010);
      send_item(MODE_REQ_SNAP, 32'h0000_0000);
      send_item(MODE_READ_SNAP, 32'h0000_0000);
      send_item(MODE_EDGE, 32'h0000_0030);
      send_item(MODE_READ_SNAP, 32'hFFFF_FFFF);
      send_item(MODE_UNUSED_6, 32'h5555_AAAA);
      send_item(MODE_READ_FINAL, 32'h0000_0000);
      send_item(MODE_READ_FINAL, 32'h0000_0000);
   endtask

   // Pulses with no elapsed cycles: both reads answer invalid, final read still stops
   task automatic test_zero_cycle_total();
      send_item(MODE_ARM, 32'h0000_0000);
      send_item(MODE_EDGE, 32'h0000_0000);
      send_item(MODE_EDGE, 32'h0000_0000);
      send_item(MODE_REQ_SNAP, 32'h0000_0000);
      send_item(MODE_EDGE, 32'h0000_0000);
      send_item(MODE_READ_SNAP, 32'h0000_0000);
      send_item(MODE_READ_FINAL, 32'h0000_0000);
      send_item(MODE_EDGE, 32'hFFFF_FFFF);
      send_item(MODE_READ_FINAL, 32'hFFFF_FFFF);
   endtask

   // Cycle total wraps past 2^COUNT_WIDTH
   task automatic test_count_wrap();
      send_item(MODE_ARM, 32'h0000_0000);
      send_item(MODE_EDGE, 32'h0000_0000);
      send_item(MODE_EDGE, 32'hFFFF_FFFF);
      send_item(MODE_EDGE, 32'hFFFF_FFFE);
      send_item(MODE_REQ_SNAP, 32'h0000_0000);
      send_item(MODE_EDGE, 32'hFFFF_FFFD);
      send_item(MODE_READ_SNAP, 32'h0000_0000);
      send_item(MODE_READ_FINAL, 32'h0000_0000);
   endtask

   // Extreme register settings, including zero values, saturation and a masked divider
   task automatic test_register_extremes();
      logic [CSR_DATA_W-1:0] div_values[5] = '{32'h0, 32'hFFFF, 32'h1, 32'hFFFF, 32'hFFFF_FFFF};
      logic [CSR_DATA_W-1:0] clk_values[5] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1};
      logic [STAMP_W-1:0]    stamp;
      write_register(REG_SPARE_2, $urandom);
      write_register(REG_SPARE_3, $urandom);
      for (int s = 0; s < 5; s++) begin
         write_register(REG_DIVIDER, div_values[s]);
         write_register(REG_CLOCK, clk_values[s]);
         stamp = $urandom;
         send_item(MODE_ARM, $urandom);
         send_item(MODE_EDGE, stamp);
         send_item(MODE_EDGE, stamp + 1'b1);
         send_item(MODE_REQ_SNAP, $urandom);
         send_item(MODE_EDGE, stamp + 32'($urandom_range(2, 1000)));
         send_item(MODE_READ_SNAP, $urandom);
         send_item(MODE_READ_FINAL, $urandom);
      end
      write_register(REG_DIVIDER, 32'(DIVIDER_RESET));
      write_register(REG_CLOCK, 32'(CLOCK_RESET));
   endtask

   // Mostly well-formed measurements with random periods, some noise, occasional reconfig
   task automatic test_random_sessions();
      int                    target;
      int                    edges;
      int                    snap_at;
      int                    jitter;
      logic [STAMP_W-1:0]    stamp;
      logic [STAMP_W-1:0]    period;
      logic [CSR_DATA_W-1:0] div_value;
      logic [CSR_DATA_W-1:0] clk_value;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         // reconfigure between sessions, favoring the extremes
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0:       div_value = '1;
               1:       div_value = $urandom_range(0, 1);
               2:       div_value = $urandom_range(1, 16);
               default: div_value = $urandom;
            endcase
            case ($urandom_range(0, 3))
               0:       clk_value = '1;
               1:       clk_value = $urandom_range(0, 1);
               2:       clk_value = 32'(CLOCK_RESET);
               default: clk_value = $urandom;
            endcase
            write_register(REG_DIVIDER, div_value);
            write_register(REG_CLOCK, clk_value);
         end
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            // noise: any mode, any timestamp
            repeat ($urandom_range(1, 6)) send_item(3'($urandom_range(0, 7)), $urandom);
         end else begin
            case ($urandom_range(0, 3))
               0:       period = $urandom_range(0, 3);
               1:       period = $urandom_range(1, 2000);
               2:       period = $urandom_range(1, 1 << 20);
               default: period = $urandom;
            endcase
            jitter  = $urandom_range(0, 15);
            edges   = $urandom_range(0, 24);
            snap_at = $urandom_range(0, edges + 1);
            stamp   = $urandom;
            send_item(MODE_ARM, $urandom);
            for (int n = 0; n <= edges; n++) begin
               if (n == snap_at)
                  send_item(MODE_REQ_SNAP, $urandom);
               send_item(MODE_EDGE, stamp);
               stamp = stamp + period + 32'($urandom_range(0, jitter));
               if ($urandom_range(0, 5) == 0)
                  send_item(MODE_READ_SNAP, $urandom);
            end
            send_item(MODE_READ_SNAP, $urandom);
            if ($urandom_range(0, 9) != 0)
               send_item(MODE_READ_FINAL, $urandom);
         end
      end
      send_burst = 1'b0;
      recv_burst = 1'b0;
      drain_results();
   endtask

   // Accept results with random stalls and compare against the oldest prediction
   initial begin : result_checker
      int      stall;
      rsp_type expected;
      wait (reset == 1'b0);
      forever begin
         stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, valid_res %0b frequency %h",
                     $time, rsp_data.valid_res, rsp_data.frequency);
         end else begin
            expected = pending_results.pop_front();
            if (rsp_data.valid_res !== expected.valid_res) begin
               error_count++;
               $display("%0t: valid_res expected %0b actual %0b",
                        $time, expected.valid_res, rsp_data.valid_res);
            end
            if (rsp_data.frequency !== expected.frequency) begin
               error_count++;
               $display("%0t: frequency expected %h actual %h",
                        $time, expected.frequency, rsp_data.frequency);
            end
         end
      end
   end

   // Reset once, run every test, then settle and report
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_commands();
      test_wrapping_measurement();
      test_zero_cycle_total();
      test_count_wrap();
      test_register_extremes();
      test_random_sessions();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("reciprocal_frequency_counter_top: match");
      else
         $display("reciprocal_frequency_counter_top: mismatch");
      $finish;
   end

endmodule
